// ===== hw/rtl/point_quad_expander_assert.svh =====
// Assertion macros shared by the point quad expander modules
`ifndef POINT_QUAD_EXPANDER_ASSERT_SVH
`define POINT_QUAD_EXPANDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PQE_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PQE_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pqe_pkg.sv =====
// Types and constants of the point quad expander
package pqe_pkg;

  localparam logic [15:0] EXTENT_RESET  = 16'd8192;
  localparam logic [16:0] SEG_LIMIT     = 17'd65531;
  localparam logic [16:0] QUAD_VERTS_17 = 17'd4;
  localparam logic [32:0] QUAD_VERTS_33 = 33'd4;
  localparam logic [15:0] SEG_MAX       = 16'hFFFF;
  localparam int          QDEPTH        = 4;
  localparam int          QPTR_W        = $clog2(QDEPTH);
  localparam int          QCNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_QUAD  = 1'b0,
    KIND_RANGE = 1'b1
  } kind_t;

  typedef struct packed {
    logic        has_quad;
    logic        has_range;
    logic [14:0] quad_x;
    logic [14:0] quad_y;
    logic [15:0] base_index;
    logic        segment_started;
    logic [15:0] segment_number;
    logic [31:0] feature_id;
    logic [31:0] first_vertex;
    logic [31:0] vertex_count;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

// ===== hw/rtl/pqe_if.sv =====
// Point and result channel interfaces
interface pqe_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic        [31:0] feature_id;
  logic               feature_end;

  modport source (output valid, point_x, point_y, feature_id, feature_end, input ready);
  modport sink (input valid, point_x, point_y, feature_id, feature_end, output ready);
endinterface

interface pqe_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [14:0] quad_x;
  logic [14:0] quad_y;
  logic [15:0] base_index;
  logic        segment_started;
  logic [15:0] segment_number;
  logic [31:0] range_feature;
  logic [31:0] range_first_vertex;
  logic [31:0] range_vertex_count;
  logic        last_result;

  modport source (output valid, result_kind, quad_x, quad_y, base_index, segment_started,
                  segment_number, range_feature, range_first_vertex, range_vertex_count,
                  last_result, input ready);
  modport sink (input valid, result_kind, quad_x, quad_y, base_index, segment_started,
                segment_number, range_feature, range_first_vertex, range_vertex_count,
                last_result, output ready);
endinterface

// ===== hw/rtl/pqe_front.sv =====
// Front end: point classification, segment and vertex counters
module pqe_front
  import pqe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  pqe_point_if.sink        pt,
  input  qstat_t           qstat,
  output logic             push,
  output entry_t           entry
);

  logic [15:0] tile_extent;
  logic [31:0] total_vertex_count;
  logic [16:0] segment_vertex_count;
  logic [15:0] current_segment;
  logic [31:0] feature_start_vertex;
  logic        at_feature_start;

  logic [31:0] total_vertex_count_next;
  logic [16:0] segment_vertex_count_next;
  logic [15:0] current_segment_next;
  logic [31:0] fsv;
  logic        x_ok, y_ok, keep, seg_open, range_hit, accept;
  logic [32:0] total_sum;
  logic [15:0] base;

  assign accept = pt.valid && pt.ready;
  assign pt.ready = !qstat.full;

  assign x_ok = (pt.point_x[15:14] == 2'b00) && ({2'b00, pt.point_x[13:0]} < tile_extent);
  assign y_ok = (pt.point_y[15:14] == 2'b00) && ({2'b00, pt.point_y[13:0]} < tile_extent);
  assign keep = x_ok && y_ok;

  assign fsv       = at_feature_start ? total_vertex_count : feature_start_vertex;
  assign seg_open  = segment_vertex_count > SEG_LIMIT;
  assign total_sum = {1'b0, total_vertex_count} + QUAD_VERTS_33;

  always_comb begin
    base                      = segment_vertex_count[15:0];
    segment_vertex_count_next = segment_vertex_count;
    current_segment_next      = current_segment;
    total_vertex_count_next   = total_vertex_count;
    if (keep) begin
      if (seg_open) begin
        base = '0;
        segment_vertex_count_next = QUAD_VERTS_17;
        if (current_segment != SEG_MAX) begin
          current_segment_next = current_segment + 16'd1;
        end
      end else begin
        segment_vertex_count_next = segment_vertex_count + QUAD_VERTS_17;
      end
      total_vertex_count_next = total_sum[32] ? '1 : total_sum[31:0];
    end
  end

  assign range_hit = pt.feature_end && (total_vertex_count_next > fsv);
  assign push      = accept && (keep || range_hit);

  always_comb begin
    entry.has_quad        = keep;
    entry.has_range       = range_hit;
    entry.quad_x          = {pt.point_x[13:0], 1'b0};
    entry.quad_y          = {pt.point_y[13:0], 1'b0};
    entry.base_index      = base;
    entry.segment_started = seg_open;
    entry.segment_number  = current_segment_next;
    entry.feature_id      = pt.feature_id;
    entry.first_vertex    = fsv;
    entry.vertex_count    = total_vertex_count_next - fsv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_extent          <= EXTENT_RESET;
      total_vertex_count   <= '0;
      segment_vertex_count <= '0;
      current_segment      <= '0;
      feature_start_vertex <= '0;
      at_feature_start     <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        tile_extent <= cfg_wr_data;
      end
      if (accept) begin
        total_vertex_count   <= total_vertex_count_next;
        segment_vertex_count <= segment_vertex_count_next;
        current_segment      <= current_segment_next;
        feature_start_vertex <= fsv;
        at_feature_start     <= pt.feature_end;
      end
    end
  end

endmodule

// ===== hw/rtl/pqe_queue.sv =====
// Short queue between front and back ends
module pqe_queue
  import pqe_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qctl_t  ctl,
  input  entry_t wr_entry,
  output entry_t rd_entry,
  output qstat_t stat
);
`include "point_quad_expander_assert.svh"

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign stat.full     = count == QCNT_W'(QDEPTH);
  assign stat.nonempty = count != '0;
  assign do_push       = ctl.push && !stat.full;
  assign do_pop        = ctl.pop && stat.nonempty;
  assign rd_entry      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `PQE_ASSERT_NOW(a_count_bound, 1'b1, count <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `PQE_ASSERT_NOW(a_no_push_full, ctl.push, !stat.full, "push into full queue")
  `PQE_ASSERT_NOW(a_no_pop_empty, ctl.pop, stat.nonempty, "pop from empty queue")

endmodule

// ===== hw/rtl/pqe_back.sv =====
// Back end: expands queue entries into result words
module pqe_back
  import pqe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  entry_t       rd_entry,
  input  qstat_t       qstat,
  output logic         pop,
  pqe_result_if.source res
);
`include "point_quad_expander_assert.svh"

  logic        out_valid;
  logic        pending;
  logic [31:0] held_feature;
  logic [31:0] held_first;
  logic [31:0] held_count;
  logic        can_load;

  assign can_load  = !out_valid || res.ready;
  assign pop       = can_load && !pending && qstat.nonempty;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (can_load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (qstat.nonempty) begin
        out_valid <= 1'b1;
        pending   <= rd_entry.has_quad && rd_entry.has_range;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pending || (qstat.nonempty && !rd_entry.has_quad)) begin
        res.result_kind        <= KIND_RANGE;
        res.quad_x             <= '0;
        res.quad_y             <= '0;
        res.base_index         <= '0;
        res.segment_started    <= 1'b0;
        res.segment_number     <= '0;
        res.range_feature      <= pending ? held_feature : rd_entry.feature_id;
        res.range_first_vertex <= pending ? held_first : rd_entry.first_vertex;
        res.range_vertex_count <= pending ? held_count : rd_entry.vertex_count;
        res.last_result        <= 1'b1;
      end else begin
        res.result_kind        <= KIND_QUAD;
        res.quad_x             <= rd_entry.quad_x;
        res.quad_y             <= rd_entry.quad_y;
        res.base_index         <= rd_entry.base_index;
        res.segment_started    <= rd_entry.segment_started;
        res.segment_number     <= rd_entry.segment_number;
        res.range_feature      <= rd_entry.feature_id;
        res.range_first_vertex <= '0;
        res.range_vertex_count <= '0;
        res.last_result        <= !rd_entry.has_range;
      end
      if (!pending) begin
        held_feature <= rd_entry.feature_id;
        held_first   <= rd_entry.first_vertex;
        held_count   <= rd_entry.vertex_count;
      end
    end
  end

  `PQE_ASSERT_NOW(a_pending_quad, pending,
                  out_valid && (res.result_kind == KIND_QUAD) && !res.last_result,
                  "pending range without quad word in front")
  `PQE_ASSERT_NOW(a_range_last, out_valid && (res.result_kind == KIND_RANGE),
                  res.last_result, "range word not last")
  `PQE_ASSERT_NEXT(a_range_follows, out_valid && res.ready && pending,
                   out_valid && (res.result_kind == KIND_RANGE),
                   "range word did not follow its quad")

endmodule

// ===== hw/rtl/point_quad_expander.sv =====
// Point quad expander top level
//
//   channel  | dir | handshake               | word
//   pt       | in  | valid/ready             | point_x, point_y, feature_id, feature_end
//   res      | out | valid/ready             | quad or feature range result
//   cfg      | in  | cfg_wr_en, no handshake | tile_extent
//
// One point per cycle enters unless the queue is full; results leave one word per cycle while res.ready is high.
// A point with a quad and a feature range gives two words at the back end, the quad then the range.
// A four-entry queue sits between front and back; pt.ready drops when it fills.
// Output words sit in a register; the back end refills it in the cycle it is taken.
// Reset is synchronous; it empties the queue and clears the counters.
module point_quad_expander
  import pqe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  pqe_point_if.sink    pt,
  pqe_result_if.source res
);

  entry_t wr_entry;
  entry_t rd_entry;
  qctl_t  qctl;
  qstat_t qstat;
  logic   q_push;
  logic   q_pop;

  assign qctl = '{push: q_push, pop: q_pop};

  pqe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pt          (pt),
    .qstat       (qstat),
    .push        (q_push),
    .entry       (wr_entry)
  );

  pqe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (qctl),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry),
    .stat     (qstat)
  );

  pqe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_entry (rd_entry),
    .qstat    (qstat),
    .pop      (q_pop),
    .res      (res)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for point_quad_expander: predicts quads and feature ranges, checks every word
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pqe_pkg::*;

  localparam int          COORD_MAX      = 16383;
  localparam logic [16:0] VERTS_PER_QUAD = 17'd4;
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          REPORT_CAP     = 40;

  typedef struct {
    kind_t       kind;
    logic [14:0] qx;
    logic [14:0] qy;
    logic [15:0] base;
    logic        seg_open;
    logic [15:0] seg_num;
    logic [31:0] feature;
    logic [31:0] first_vtx;
    logic [31:0] vtx_count;
    logic        last;
  } quad_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        rx_want = 1'b0;
  logic        rx_block = 1'b0;

  pqe_point_if  pt_if ();
  pqe_result_if res_if ();

  assign res_if.ready = rx_want && !rx_block;

  point_quad_expander u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pt          (pt_if),
    .res         (res_if)
  );

  logic [15:0] tile_extent       = EXTENT_RESET;
  logic [31:0] total_vtx         = '0;
  logic [16:0] seg_vtx           = '0;
  logic [15:0] cur_seg           = '0;
  logic [31:0] feature_base      = '0;
  logic        at_feature_start  = 1'b1;

  quad_word_t quad_range_q[$];

  int tx_gap_max      = 0;
  int rx_stall_max    = 0;
  int hold_len        = 0;
  int mismatch_count  = 0;
  int points_sent     = 0;
  int quads_predicted = 0;
  int words_seen      = 0;
  int quads_seen      = 0;
  int ranges_seen     = 0;
  int segs_seen       = 0;
  int extent_writes   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic quad_word_t blank_word();
    quad_word_t w;
    w.kind      = KIND_QUAD;
    w.qx        = '0;
    w.qy        = '0;
    w.base      = '0;
    w.seg_open  = 1'b0;
    w.seg_num   = '0;
    w.feature   = '0;
    w.first_vtx = '0;
    w.vtx_count = '0;
    w.last      = 1'b0;
    return w;
  endfunction

  function automatic bit coord_kept(input logic signed [15:0] c);
    int v;
    v = c;
    return v >= 0 && v < int'(tile_extent) && v <= COORD_MAX;
  endfunction

  task automatic expand_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic [31:0] fid, input logic fend);
    quad_word_t w;
    quad_word_t step_q[$];
    logic       opened;
    if (at_feature_start) begin
      feature_base     = total_vtx;
      at_feature_start = 1'b0;
    end
    if (coord_kept(x) && coord_kept(y)) begin
      opened = 1'b0;
      if (seg_vtx > SEG_LIMIT) begin
        if (cur_seg != SEG_MAX) cur_seg++;
        seg_vtx = '0;
        opened  = 1'b1;
      end
      w          = blank_word();
      w.qx       = {x[13:0], 1'b0};
      w.qy       = {y[13:0], 1'b0};
      w.base     = seg_vtx[15:0];
      w.seg_open = opened;
      w.seg_num  = cur_seg;
      w.feature  = fid;
      seg_vtx    = seg_vtx + VERTS_PER_QUAD;
      if (total_vtx > 32'hFFFF_FFFB) total_vtx = 32'hFFFF_FFFF;
      else total_vtx = total_vtx + 32'd4;
      quads_predicted++;
      step_q = {step_q, w};
    end
    if (fend) begin
      if (total_vtx > feature_base) begin
        w           = blank_word();
        w.kind      = KIND_RANGE;
        w.feature   = fid;
        w.first_vtx = feature_base;
        w.vtx_count = total_vtx - feature_base;
        step_q = {step_q, w};
      end
      at_feature_start = 1'b1;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) quad_range_q = {quad_range_q, step_q[i]};
  endtask

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [31:0] fid, input logic fend);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pt_if.valid       <= 1'b1;
    pt_if.point_x     <= x;
    pt_if.point_y     <= y;
    pt_if.feature_id  <= fid;
    pt_if.feature_end <= fend;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    expand_point(x, y, fid, fend);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int waited;
    pt_if.valid <= 1'b0;
    waited = 0;
    while (quad_range_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (quad_range_q.size() != 0) begin
      flag_mismatch($sformatf("%0d expected words never arrived", quad_range_q.size()));
      quad_range_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_extent(input logic [15:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tile_extent = value;
    extent_writes++;
  endtask

  function automatic logic signed [15:0] pick_coord(input bit in_tile);
    int lim;
    int v;
    lim = (int'(tile_extent) < COORD_MAX + 1) ? int'(tile_extent) : COORD_MAX + 1;
    if (in_tile && lim > 0) return 16'($urandom_range(0, lim - 1));
    case ($urandom_range(0, 5))
      0: return tile_extent;
      1: return tile_extent - 16'd1;
      2: return 16'(COORD_MAX);
      3: return 16'(COORD_MAX + 1);
      4: begin
        v = $urandom_range(1, 32768);
        return 16'(-v);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_feature(input int len, input int keep_pct, input bit mark_end);
    logic [31:0] fid;
    bit          keep;
    fid = $urandom;
    for (int i = 0; i < len; i++) begin
      keep = $urandom_range(0, 99) < keep_pct;
      send_point(pick_coord(keep), pick_coord(keep), fid, mark_end && (i == len - 1));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v)
      flag_mismatch($sformatf("word %0d %s: got 0x%0h, want 0x%0h",
                              words_seen, name, got_v, want_v));
  endtask

  task automatic check_word();
    quad_word_t got;
    quad_word_t want;
    got.kind      = kind_t'(res_if.result_kind);
    got.qx        = res_if.quad_x;
    got.qy        = res_if.quad_y;
    got.base      = res_if.base_index;
    got.seg_open  = res_if.segment_started;
    got.seg_num   = res_if.segment_number;
    got.feature   = res_if.range_feature;
    got.first_vtx = res_if.range_first_vertex;
    got.vtx_count = res_if.range_vertex_count;
    got.last      = res_if.last_result;
    words_seen++;
    if (got.kind == KIND_RANGE) ranges_seen++;
    else quads_seen++;
    if (got.seg_open === 1'b1) segs_seen++;
    if (quad_range_q.size() == 0) begin
      flag_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
    end else begin
      want = quad_range_q.pop_front();
      check_field("result_kind", 32'(got.kind), 32'(want.kind));
      check_field("quad_x", 32'(got.qx), 32'(want.qx));
      check_field("quad_y", 32'(got.qy), 32'(want.qy));
      check_field("base_index", 32'(got.base), 32'(want.base));
      check_field("segment_started", 32'(got.seg_open), 32'(want.seg_open));
      check_field("segment_number", 32'(got.seg_num), 32'(want.seg_num));
      check_field("range_feature", got.feature, want.feature);
      check_field("range_first_vertex", got.first_vtx, want.first_vtx);
      check_field("range_vertex_count", got.vtx_count, want.vtx_count);
      check_field("last_result", 32'(got.last), 32'(want.last));
    end
  endtask

  initial begin
    int stall;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        rx_want <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rx_want <= 1'b1;
      @(posedge clk);
      while (!(res_if.valid && res_if.ready)) @(posedge clk);
      check_word();
      @(negedge clk);
    end
  end

  initial begin
    int n;
    forever begin
      wait (hold_len != 0);
      n        = hold_len;
      hold_len = 0;
      rx_block <= 1'b1;
      repeat (n) @(negedge clk);
      rx_block <= 1'b0;
    end
  end

  task automatic test_default_extent();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    send_point(16'sd0, 16'sd0, 32'h0000_0000, 1'b1);
    send_point(16'sd8191, 16'sd8191, 32'hFFFF_FFFF, 1'b0);
    send_point(16'sd8192, 16'sd5, 32'hFFFF_FFFF, 1'b0);
    send_point(16'sd5, 16'sd8192, 32'hFFFF_FFFF, 1'b1);
    send_point(-16'sd1, 16'sd0, 32'h0000_0007, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 32'h0000_0007, 1'b1);
    send_point(16'sd32767, -16'sd32768, 32'hAAAA_5555, 1'b1);
  endtask

  task automatic test_extent_extremes();
    write_extent(16'hFFFF);
    send_point(16'sd16383, 16'sd16383, 32'h5555_AAAA, 1'b1);
    send_point(16'sd16384, 16'sd0, 32'h0000_0001, 1'b1);
    send_point(16'sd0, 16'sd16384, 32'h0000_0002, 1'b1);
    write_extent(16'h0000);
    send_point(16'sd0, 16'sd0, 32'h0000_0003, 1'b1);
    write_extent(16'h0001);
    send_point(16'sd0, 16'sd0, 32'h0000_0010, 1'b0);
    send_point(16'sd1, 16'sd0, 32'h0000_0011, 1'b0);
    send_point(16'sd0, 16'sd1, 32'h0000_0012, 1'b1);
    write_extent(16'd16384);
    send_point(16'sd16383, 16'sd0, 32'h0000_0020, 1'b1);
  endtask

  task automatic test_output_stall();
    write_extent(16'd8192);
    tx_gap_max   = 0;
    rx_stall_max = 0;
    hold_len     = 300;
    for (int i = 0; i < 20; i++) send_feature($urandom_range(1, 4), 90, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [15:0] ext_list[6];
    int          start;
    int          pick;
    ext_list = '{16'd0, 16'd16383, 16'd16385, 16'd3, 16'd32768, 16'd8192};
    ext_list[0] = 16'($urandom_range(0, 65535));
    for (int ph = 0; ph < 6; ph++) begin
      write_extent(ext_list[ph]);
      tx_gap_max   = (ph % 2 == 1) ? 19 : 0;
      rx_stall_max = (ph % 3 == 0) ? 0 : 19;
      start = points_sent;
      while (points_sent - start < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_feature($urandom_range(1, 8), 85, 1'b1);
        else if (pick < 80) send_feature($urandom_range(1, 4), 0, 1'b1);
        else if (pick < 90) send_feature($urandom_range(1, 5), 80, 1'b0);
        else send_point(pick_coord($urandom_range(0, 1)), pick_coord($urandom_range(0, 1)),
                        $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    pt_if.valid       = 1'b0;
    pt_if.point_x     = '0;
    pt_if.point_y     = '0;
    pt_if.feature_id  = '0;
    pt_if.feature_end = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_extent();
    test_extent_extremes();
    test_output_stall();
    test_random_streams();
    wait_drained();
    $display("Covered %0d points (%0d kept) over %0d extent settings, with a 300-cycle stall",
             points_sent, quads_predicted, extent_writes);
    $display("Checked %0d words: %0d quads, %0d feature ranges, %0d segment openings",
             words_seen, quads_seen, ranges_seen, segs_seen);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout: %0d words still expected", quad_range_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== point_quad_expander.f =====
+incdir+hw/rtl
hw/rtl/pqe_pkg.sv
hw/rtl/pqe_if.sv
hw/rtl/pqe_front.sv
hw/rtl/pqe_queue.sv
hw/rtl/pqe_back.sv
hw/rtl/point_quad_expander.sv
tb/tb_top.sv
